@@ rtl/assert_macros.svh @@
// Assertion macros used by the filter core RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define AMF_ASSERT(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) else $error("assertion failed");
`define AMF_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error("assertion failed");
`else
`define AMF_ASSERT(lbl, expr)
`define AMF_ASSERT_IMP(lbl, ante, cons)
`endif
`endif

@@ rtl/amf_pkg.sv @@
// Types, constants and helpers of the adaptive median filter.
package amf_pkg;

  localparam int MAX_WIDTH  = 256;
  localparam int MAX_RADIUS = 3;
  localparam int MAX_HEIGHT = 4096;

  localparam int PIX_W = 8;
  localparam int FW_W  = 9;
  localparam int FH_W  = 13;
  localparam int RAD_W = 2;
  localparam int CFG_W = 13;

  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int EW_W  = $clog2(MAX_WIDTH + 1);
  localparam int ROW_W = $clog2(MAX_HEIGHT);
  localparam int EH_W  = $clog2(MAX_HEIGHT + 1);
  localparam int LIM_W = $clog2(MAX_RADIUS + 1);
  localparam int DLY_W = $clog2(MAX_RADIUS * MAX_WIDTH + MAX_RADIUS + 1);

  localparam int WIN_SIDE  = 2 * MAX_RADIUS + 1;
  localparam int WIN_CELLS = WIN_SIDE * WIN_SIDE;
  localparam int LINES     = 2 * MAX_RADIUS;
  localparam int CNT_W     = $clog2(WIN_CELLS + 1);
  localparam int CENTER    = WIN_CELLS / 2;

  localparam logic [1:0] REG_WIDTH  = 2'd0;
  localparam logic [1:0] REG_HEIGHT = 2'd1;
  localparam logic [1:0] REG_RADIUS = 2'd2;

  typedef logic [PIX_W-1:0] pix_t;
  typedef pix_t [WIN_CELLS-1:0] cells_t;

  typedef struct packed {
    pix_t lo;
    pix_t med;
    pix_t hi;
  } stat_t;

  typedef stat_t [MAX_RADIUS:1] stats_t;

  typedef struct packed {
    logic valid;
    logic last;
  } ctl_t;

  function automatic logic in_win(int i, int s);
    int a;
    int b;
    a = i / WIN_SIDE - MAX_RADIUS;
    b = i % WIN_SIDE - MAX_RADIUS;
    return (a >= -s) && (a <= s) && (b >= -s) && (b <= s);
  endfunction

  function automatic int win_n(int s);
    return (2 * s + 1) * (2 * s + 1);
  endfunction

endpackage

@@ rtl/adaptive_median_filter_core.sv @@
// Adaptive median filter core, streaming 8-bit pixels in raster order.
//
//   channel  | signals                                  | direction
//   pixel    | pixel_valid, pixel_stall, pixel_in, flush | in
//   result   | result_valid, result_stall,               | out
//            | filtered_pixel, last_of_frame            |
//   config   | cfg_write, cfg_index, cfg_data            | in
//
// One pixel transaction per clock whenever pixel_stall is low.
// A pixel passes stages 1 to 3, amf_rank and the result register; the
// first result of a frame follows 3 rows plus 3 pixels of input.
// One line RAM, 6 pixels wide, read and written at most once per cycle.
// A result stalled on the output holds the whole pipeline and pixel_stall.
// Reset and any register write restart the frame counters.
module adaptive_median_filter_core (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      pixel_valid,
  output logic                      pixel_stall,
  input  logic [amf_pkg::PIX_W-1:0] pixel_in,
  input  logic                      flush,
  output logic                      result_valid,
  input  logic                      result_stall,
  output logic [amf_pkg::PIX_W-1:0] filtered_pixel,
  output logic                      last_of_frame,
  input  logic                      cfg_write,
  input  logic [1:0]                cfg_index,
  input  logic [amf_pkg::CFG_W-1:0] cfg_data
);
  import amf_pkg::*;

`include "assert_macros.svh"

  logic [FW_W-1:0]  frame_width;
  logic [FH_W-1:0]  frame_height;
  logic [RAD_W-1:0] max_window_radius;
  logic [EW_W-1:0]  w_eff;
  logic [EH_W-1:0]  h_eff;
  logic [LIM_W-1:0] lim;
  logic [DLY_W-1:0] delay;

  logic             adv;
  logic             accept;
  logic             restart;
  logic             col_wrap;
  logic             last_pos;
  logic [COL_W-1:0] in_col;
  logic [DLY_W-1:0] pre_cnt;
  logic [ROW_W-1:0] out_row;
  logic [COL_W-1:0] out_col;

  logic             s1_valid;
  pix_t             s1_pix;
  logic [COL_W-1:0] s1_col;
  logic             s1_emit;
  logic [ROW_W-1:0] s1_row;
  logic [COL_W-1:0] s1_ocol;
  logic             s1_last;

  logic [LINES*PIX_W-1:0] ram_q;
  logic [LINES*PIX_W-1:0] rd_eff;
  logic [LINES*PIX_W-1:0] wdata;
  logic [LINES*PIX_W-1:0] byp_data;
  logic                   byp;

  pix_t col_vec [WIN_SIDE];
  pix_t win [WIN_SIDE][WIN_SIDE];

  logic             s2_valid;
  logic [ROW_W-1:0] s2_row;
  logic [COL_W-1:0] s2_col;
  logic             s2_last;
  logic [WIN_SIDE-1:0] row_ok;
  logic [WIN_SIDE-1:0] col_ok;
  cells_t           cells_next;
  cells_t           s3_cells;
  ctl_t             s3_ctl;

  ctl_t   d_ctl;
  stats_t stats;
  pix_t   centre;
  pix_t   res;
  pix_t   fb;
  logic   done;

  // effective register values
  always_comb begin
    if (frame_width == '0) begin
      w_eff = EW_W'(1);
    end else if (int'(frame_width) > MAX_WIDTH) begin
      w_eff = EW_W'(MAX_WIDTH);
    end else begin
      w_eff = EW_W'(frame_width);
    end
    if (frame_height == '0) begin
      h_eff = EH_W'(1);
    end else if (int'(frame_height) > MAX_HEIGHT) begin
      h_eff = EH_W'(MAX_HEIGHT);
    end else begin
      h_eff = EH_W'(frame_height);
    end
    if (max_window_radius == '0) begin
      lim = LIM_W'(1);
    end else if (int'(max_window_radius) > MAX_RADIUS) begin
      lim = LIM_W'(MAX_RADIUS);
    end else begin
      lim = LIM_W'(max_window_radius);
    end
  end

  assign delay    = DLY_W'(MAX_RADIUS) * DLY_W'(w_eff) + DLY_W'(MAX_RADIUS);
  assign adv      = !(result_valid && result_stall);
  assign pixel_stall = !adv;
  assign accept   = pixel_valid && adv;
  assign restart  = cfg_write && ((cfg_index == REG_WIDTH) || (cfg_index == REG_HEIGHT) ||
                                  (cfg_index == REG_RADIUS));
  assign col_wrap = EW_W'(in_col) == w_eff - EW_W'(1);
  assign last_pos = (EH_W'(out_row) == h_eff - EH_W'(1)) &&
                    (EW_W'(out_col) == w_eff - EW_W'(1));

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width       <= FW_W'(256);
      frame_height      <= FH_W'(256);
      max_window_radius <= RAD_W'(3);
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_WIDTH:  frame_width       <= cfg_data[FW_W-1:0];
        REG_HEIGHT: frame_height      <= cfg_data[FH_W-1:0];
        REG_RADIUS: max_window_radius <= cfg_data[RAD_W-1:0];
        default: ;
      endcase
    end
  end

  // input and output position counters
  always_ff @(posedge clk) begin
    if (rst || restart) begin
      in_col  <= '0;
      pre_cnt <= '0;
      out_row <= '0;
      out_col <= '0;
    end else if (accept) begin
      in_col <= col_wrap ? '0 : in_col + 1'b1;
      if (pre_cnt != delay) begin
        pre_cnt <= pre_cnt + 1'b1;
      end else if (last_pos) begin
        in_col  <= '0;
        pre_cnt <= '0;
        out_row <= '0;
        out_col <= '0;
      end else if (EW_W'(out_col) == w_eff - EW_W'(1)) begin
        out_col <= '0;
        out_row <= out_row + 1'b1;
      end else begin
        out_col <= out_col + 1'b1;
      end
    end
  end

  // stage 1: pixel registered, line RAM read in flight
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      byp      <= 1'b0;
    end else if (adv) begin
      s1_valid <= pixel_valid;
      byp      <= s1_valid && (in_col == s1_col);
    end
    if (adv) begin
      s1_pix   <= flush ? '0 : pixel_in;
      s1_col   <= in_col;
      s1_emit  <= pre_cnt == delay;
      s1_row   <= out_row;
      s1_ocol  <= out_col;
      s1_last  <= last_pos;
      byp_data <= wdata;
    end
  end

  amf_ram #(
    .WIDTH(LINES * PIX_W),
    .DEPTH(MAX_WIDTH)
  ) u_lines (
    .clk  (clk),
    .we   (adv && s1_valid),
    .waddr(s1_col),
    .wdata(wdata),
    .re   (adv),
    .raddr(in_col),
    .rdata(ram_q)
  );

  // same-address write in the read cycle
  assign rd_eff = byp ? byp_data : ram_q;
  assign wdata  = {rd_eff[(LINES-1)*PIX_W-1:0], s1_pix};

  always_comb begin
    col_vec[0] = s1_pix;
    for (int k = 1; k < WIN_SIDE; k++) begin
      col_vec[k] = rd_eff[(k-1)*PIX_W +: PIX_W];
    end
  end

  always_ff @(posedge clk) begin
    if (adv && s1_valid) begin
      win[0] <= col_vec;
      for (int j = 1; j < WIN_SIDE; j++) begin
        win[j] <= win[j-1];
      end
    end
  end

  // stage 2: window and output position
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (adv) begin
      s2_valid <= s1_valid && s1_emit;
    end
    if (adv) begin
      s2_row  <= s1_row;
      s2_col  <= s1_ocol;
      s2_last <= s1_last;
    end
  end

  // zero padding outside the frame
  always_comb begin
    for (int k = 0; k < WIN_SIDE; k++) begin
      if (k < MAX_RADIUS) begin
        row_ok[k] = s2_row >= ROW_W'(MAX_RADIUS - k);
        col_ok[k] = s2_col >= COL_W'(MAX_RADIUS - k);
      end else begin
        row_ok[k] = (EH_W+1)'(s2_row) + (EH_W+1)'(k - MAX_RADIUS) < (EH_W+1)'(h_eff);
        col_ok[k] = (EW_W+1)'(s2_col) + (EW_W+1)'(k - MAX_RADIUS) < (EW_W+1)'(w_eff);
      end
    end
    for (int a = 0; a < WIN_SIDE; a++) begin
      for (int b = 0; b < WIN_SIDE; b++) begin
        cells_next[a*WIN_SIDE+b] = (row_ok[a] && col_ok[b]) ?
                                   win[WIN_SIDE-1-b][WIN_SIDE-1-a] : '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_ctl <= '0;
    end else if (adv) begin
      s3_ctl <= '{valid: s2_valid, last: s2_last};
    end
    if (adv) begin
      s3_cells <= cells_next;
    end
  end

  amf_rank u_rank (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .ctl_in    (s3_ctl),
    .cells_in  (s3_cells),
    .ctl_out   (d_ctl),
    .stats_out (stats),
    .centre_out(centre)
  );

  // window growth decision
  always_comb begin
    res  = '0;
    fb   = '0;
    done = 1'b0;
    for (int s = 1; s <= MAX_RADIUS; s++) begin
      if (LIM_W'(s) == lim) begin
        fb = stats[s].med;
      end
      if (!done && (LIM_W'(s) <= lim) && (stats[s].lo < stats[s].med) &&
          (stats[s].med < stats[s].hi)) begin
        res  = ((stats[s].lo < centre) && (centre < stats[s].hi)) ? centre : stats[s].med;
        done = 1'b1;
      end
    end
    if (!done) begin
      res = fb;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (adv) begin
      result_valid <= d_ctl.valid;
    end
    if (adv) begin
      filtered_pixel <= res;
      last_of_frame  <= d_ctl.last;
    end
  end

  `AMF_ASSERT(a_pre_bound, pre_cnt <= delay)
  `AMF_ASSERT(a_out_row, EH_W'(out_row) < h_eff)
  `AMF_ASSERT_IMP(a_out_col, pre_cnt == delay, EW_W'(out_col) < w_eff)

endmodule

@@ rtl/amf_ram.sv @@
// Generic single-port-write RAM with registered read.
module amf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ rtl/amf_rank.sv @@
// Rank-based min, median and max of each nested window, three stages.
module amf_rank (
  input  logic            clk,
  input  logic            rst,
  input  logic            adv,
  input  amf_pkg::ctl_t   ctl_in,
  input  amf_pkg::cells_t cells_in,
  output amf_pkg::ctl_t   ctl_out,
  output amf_pkg::stats_t stats_out,
  output amf_pkg::pix_t   centre_out
);
  import amf_pkg::*;

  logic [WIN_CELLS-1:0] lt [WIN_CELLS];
  cells_t cells1;
  cells_t cells2;
  ctl_t   ctl1;
  ctl_t   ctl2;

  logic [CNT_W-1:0] lt_cnt [1:MAX_RADIUS][WIN_CELLS];
  logic [CNT_W-1:0] le_cnt [1:MAX_RADIUS][WIN_CELLS];
  logic [CNT_W-1:0] lt_q   [1:MAX_RADIUS][WIN_CELLS];
  logic [CNT_W-1:0] le_q   [1:MAX_RADIUS][WIN_CELLS];
  stats_t st;

  // pairwise compares
  always_ff @(posedge clk) begin
    if (rst) begin
      ctl1 <= '0;
    end else if (adv) begin
      ctl1 <= ctl_in;
    end
    if (adv) begin
      cells1 <= cells_in;
      for (int i = 0; i < WIN_CELLS; i++) begin
        for (int j = 0; j < WIN_CELLS; j++) begin
          lt[i][j] <= cells_in[j] < cells_in[i];
        end
      end
    end
  end

  // counts of smaller and not-larger cells per window size
  always_comb begin
    for (int s = 1; s <= MAX_RADIUS; s++) begin
      for (int i = 0; i < WIN_CELLS; i++) begin
        lt_cnt[s][i] = '0;
        le_cnt[s][i] = '0;
        for (int j = 0; j < WIN_CELLS; j++) begin
          if (in_win(j, s)) begin
            lt_cnt[s][i] = lt_cnt[s][i] + CNT_W'(lt[i][j]);
            le_cnt[s][i] = le_cnt[s][i] + CNT_W'(!lt[j][i]);
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl2 <= '0;
    end else if (adv) begin
      ctl2 <= ctl1;
    end
    if (adv) begin
      cells2 <= cells1;
      lt_q   <= lt_cnt;
      le_q   <= le_cnt;
    end
  end

  // sorted[k] is the value v with rank(<v) <= k < rank(<=v)
  always_comb begin
    st = '0;
    for (int s = 1; s <= MAX_RADIUS; s++) begin
      for (int i = 0; i < WIN_CELLS; i++) begin
        if (in_win(i, s)) begin
          if (lt_q[s][i] == '0) begin
            st[s].lo = st[s].lo | cells2[i];
          end
          if (le_q[s][i] == CNT_W'(win_n(s))) begin
            st[s].hi = st[s].hi | cells2[i];
          end
          if ((lt_q[s][i] <= CNT_W'(win_n(s) >> 1)) &&
              (le_q[s][i] > CNT_W'(win_n(s) >> 1))) begin
            st[s].med = st[s].med | cells2[i];
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_out <= '0;
    end else if (adv) begin
      ctl_out <= ctl2;
    end
    if (adv) begin
      stats_out  <= st;
      centre_out <= cells2[CENTER];
    end
  end

endmodule

@@ sim/testbench.sv @@
// Self-checking testbench for the adaptive median filter core.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import amf_pkg::*;

  localparam int RING       = 2 * MAX_RADIUS * MAX_WIDTH + 2 * MAX_RADIUS + 1;
  localparam int SETTLE     = 24;
  localparam int HOLD_CYCLES = 300;
  localparam int CYCLE_LIMIT = 3000000;

  typedef struct {
    logic [PIX_W-1:0] pix;
    logic             last;
  } pix_result_t;

  class median_scoreboard;
    logic [FW_W-1:0]  width_reg;
    logic [FH_W-1:0]  height_reg;
    logic [RAD_W-1:0] radius_reg;
    logic [PIX_W-1:0] ring [RING];
    int unsigned      col;
    int unsigned      row;
    int unsigned      out_pos;
    pix_result_t      pending [$];
    int               errors;

    function new();
      width_reg  = FW_W'(256);
      height_reg = FH_W'(256);
      radius_reg = RAD_W'(3);
      foreach (ring[i]) ring[i] = '0;
      col = 0;
      row = 0;
      out_pos = 0;
      errors = 0;
    endfunction

    function int unsigned eff_w();
      if (width_reg == 0) return 1;
      return (width_reg > MAX_WIDTH) ? MAX_WIDTH : width_reg;
    endfunction

    function int unsigned eff_h();
      if (height_reg == 0) return 1;
      return (height_reg > MAX_HEIGHT) ? MAX_HEIGHT : height_reg;
    endfunction

    function int eff_r();
      if (radius_reg == 0) return 1;
      return (radius_reg > MAX_RADIUS) ? MAX_RADIUS : radius_reg;
    endfunction

    function void write_reg(logic [1:0] idx, logic [CFG_W-1:0] val);
      case (idx)
        REG_WIDTH:  width_reg = val[FW_W-1:0];
        REG_HEIGHT: height_reg = val[FH_W-1:0];
        REG_RADIUS: radius_reg = val[RAD_W-1:0];
        default: return;
      endcase
      col = 0;
      row = 0;
      out_pos = 0;
    endfunction

    function logic [PIX_W-1:0] fetch(int m, int n, int w, int h);
      if (m < 0 || n < 0 || m >= h || n >= w) return '0;
      return ring[(m * w + n) % RING];
    endfunction

    function logic [PIX_W-1:0] adaptive_median(int r, int c, int w, int h);
      logic [PIX_W-1:0] cells [WIN_CELLS];
      logic [PIX_W-1:0] centre;
      logic [PIX_W-1:0] med;
      logic [PIX_W-1:0] lo;
      logic [PIX_W-1:0] hi;
      logic [PIX_W-1:0] t;
      int cnt;
      int b;
      centre = fetch(r, c, w, h);
      med = '0;
      for (int s = 1; s <= eff_r(); s++) begin
        cnt = 0;
        for (int m = r - s; m <= r + s; m++)
          for (int n = c - s; n <= c + s; n++) begin
            cells[cnt] = fetch(m, n, w, h);
            cnt++;
          end
        for (int a = 1; a < cnt; a++) begin
          t = cells[a];
          b = a - 1;
          while (b >= 0 && cells[b] > t) begin
            cells[b + 1] = cells[b];
            b--;
          end
          cells[b + 1] = t;
        end
        lo = cells[0];
        hi = cells[cnt - 1];
        med = cells[cnt / 2];
        if (lo < med && med < hi) return (lo < centre && centre < hi) ? centre : med;
      end
      return med;
    endfunction

    function void note_pixel(logic [PIX_W-1:0] p, logic f);
      int unsigned w;
      int unsigned h;
      int unsigned q;
      int unsigned pos;
      pix_result_t e;
      w = eff_w();
      h = eff_h();
      q = row * w + col;
      ring[q % RING] = f ? '0 : p;
      col++;
      if (col >= w) begin
        col = 0;
        row++;
      end
      if (q < MAX_RADIUS * w + MAX_RADIUS) return;
      pos = out_pos;
      e.pix = adaptive_median(pos / w, pos % w, w, h);
      if (pos + 1 >= w * h) begin
        e.last = 1'b1;
        col = 0;
        row = 0;
        out_pos = 0;
      end else begin
        e.last = 1'b0;
        out_pos = pos + 1;
      end
      pending.push_back(e);
    endfunction

    task report(string msg);
      $display("mismatch: %s", msg);
      errors++;
    endtask

    task check_result(logic [PIX_W-1:0] p, logic l);
      pix_result_t e;
      if (pending.size() == 0) begin
        report($sformatf("unexpected transaction pixel=%0d last=%b", p, l));
        return;
      end
      e = pending.pop_front();
      if (p !== e.pix) report($sformatf("filtered_pixel %0d, want %0d", p, e.pix));
      if (l !== e.last) report($sformatf("last_of_frame %b, want %b", l, e.last));
    endtask

    task final_check();
      if (pending.size() != 0) report($sformatf("%0d transactions missing", pending.size()));
    endtask
  endclass

  logic             clk;
  logic             rst;
  logic             pixel_valid;
  logic             pixel_stall;
  logic [PIX_W-1:0] pixel_in;
  logic             flush;
  logic             result_valid;
  logic             result_stall;
  logic [PIX_W-1:0] filtered_pixel;
  logic             last_of_frame;
  logic             cfg_write;
  logic [1:0]       cfg_index;
  logic [CFG_W-1:0] cfg_data;

  median_scoreboard sb;
  int  cycles;
  bit  quiet;
  bit  hold_req;
  int  hold_left;
  int  stall_left;
  int  random_items;

  adaptive_median_filter_core DUT (
    .clk(clk), .rst(rst),
    .pixel_valid(pixel_valid), .pixel_stall(pixel_stall),
    .pixel_in(pixel_in), .flush(flush),
    .result_valid(result_valid), .result_stall(result_stall),
    .filtered_pixel(filtered_pixel), .last_of_frame(last_of_frame),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 80) return $urandom_range(1, 3);
    if (r < 96) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  always @(posedge clk)
    if (!rst && result_valid && !result_stall) sb.check_result(filtered_pixel, last_of_frame);

  always @(negedge clk) begin
    if (hold_req) begin
      hold_left = HOLD_CYCLES;
      hold_req = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      result_stall <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      result_stall <= 1'b1;
    end else if (!quiet && $urandom_range(0, 4) == 0) begin
      stall_left = gap_len() - 1;
      result_stall <= 1'b1;
    end else begin
      result_stall <= 1'b0;
    end
  end

  task send_pixel(logic [PIX_W-1:0] p, logic f);
    int gap;
    gap = (!quiet && $urandom_range(0, 3) == 0) ? gap_len() : 0;
    repeat (gap) begin
      @(negedge clk);
      pixel_valid <= 1'b0;
    end
    @(negedge clk);
    pixel_valid <= 1'b1;
    pixel_in <= p;
    flush <= f;
    @(posedge clk);
    while (pixel_stall) @(posedge clk);
    sb.note_pixel(p, f);
  endtask

  task drain();
    @(negedge clk);
    pixel_valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
  endtask

  task write_cfg(logic [1:0] idx, logic [CFG_W-1:0] val);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    sb.write_reg(idx, val);
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  task set_frame(int w, int h, int r);
    drain();
    repeat (SETTLE) @(posedge clk);
    write_cfg(REG_WIDTH, CFG_W'(w));
    write_cfg(REG_HEIGHT, CFG_W'(h));
    write_cfg(REG_RADIUS, CFG_W'(r));
  endtask

  function automatic logic [PIX_W-1:0] noisy_pixel(logic [PIX_W-1:0] base);
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 8'd0;
    if (r == 1) return 8'd255;
    if (r == 2) return PIX_W'($urandom_range(0, 255));
    return PIX_W'(int'(base) + int'($urandom_range(0, 15)) - 8);
  endfunction

  task run_frames(int w, int h, int r, int frames, bit pressure);
    int n;
    logic [PIX_W-1:0] base;
    set_frame(w, h, r);
    n = frames * sb.eff_w() * sb.eff_h() + MAX_RADIUS * sb.eff_w() + MAX_RADIUS
        + $urandom_range(0, 4);
    base = PIX_W'($urandom_range(20, 235));
    for (int i = 0; i < n; i++) begin
      if (pressure && i == n / 3) hold_req = 1'b1;
      if (pressure && i == (2 * n) / 3) drain();
      send_pixel(noisy_pixel(base), $urandom_range(0, 9) == 0);
      random_items++;
    end
  endtask

  initial begin
    logic [PIX_W-1:0] frame3 [9] = '{255, 0, 255, 0, 128, 0, 255, 0, 255};
    int w;
    int h;
    sb = new();
    cycles = 0;
    quiet = 1'b0;
    hold_req = 1'b0;
    hold_left = 0;
    stall_left = 0;
    random_items = 0;
    rst = 1'b1;
    pixel_valid = 1'b0;
    pixel_in = '0;
    flush = 1'b0;
    cfg_write = 1'b0;
    cfg_index = REG_WIDTH;
    cfg_data = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    set_frame(3, 3, 1);
    foreach (frame3[i]) send_pixel(frame3[i], 1'b0);
    send_pixel(8'd255, 1'b1);
    send_pixel(8'd0, 1'b1);
    send_pixel(8'd77, 1'b0);
    send_pixel(8'd255, 1'b0);
    for (int i = 0; i < 8; i++) send_pixel(PIX_W'($urandom_range(0, 255)), 1'b1);

    run_frames(8, 6, 3, 3, 1'b1);
    run_frames(1, 1, 1, 5, 1'b0);
    run_frames(0, 0, 0, 3, 1'b0);
    quiet = 1'b1;
    run_frames(16, 4, 2, 1, 1'b0);
    quiet = 1'b0;
    run_frames(511, 1, 3, 1, 1'b0);
    while (random_items < 2000) begin
      quiet = ($urandom_range(0, 4) == 0);
      w = $urandom_range(1, 12);
      h = $urandom_range(1, 10);
      run_frames(w, h, $urandom_range(0, 3), $urandom_range(1, 3), 1'b0);
    end
    quiet = 1'b0;

    drain();
    repeat (SETTLE) @(posedge clk);
    sb.final_check();
    if (sb.errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end
endmodule
